[sv/playfair_digraph_cipher_macros.svh]
// assertion macros for the playfair digraph cipher
// no dependencies; taken in by the files that hold concurrent checks
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define PFC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// antecedent implies consequent on the next edge
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define PFC_ASSERT(lbl, clk, rst_n, prop)
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[sv/pfc_pkg.sv]
// shared types, constants and grid helpers for the playfair digraph cipher
// no dependencies
package pfc_pkg;

  localparam int GridSide    = 5;
  localparam int Cells       = GridSide * GridSide;
  localparam int LetterCount = 26;
  localparam int LetterW     = 5;
  localparam int RowW        = $clog2(GridSide);

  localparam logic [LetterW-1:0] LetterI    = 5'd8;
  localparam logic [LetterW-1:0] LetterJ    = 5'd9;
  localparam logic [LetterW-1:0] LetterX    = 5'd23;
  localparam logic [LetterW-1:0] LetterLast = 5'(LetterCount - 1);
  localparam logic [6:0]         AsciiA     = 7'd65;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_KEY_END = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_MSG_END = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_EMIT0,
    ST_EMIT1
  } state_e;

  typedef struct packed {
    logic ok;
    logic [LetterW-1:0] idx;
  } letter_t;

  typedef struct packed {
    logic place;
    logic fill_start;
    logic fill_step;
    logic fill_done;
    logic hold;
    logic pair_text;
    logic pair_pad;
    logic look_a;
    logic look_b;
    logic emit0;
    logic emit1;
  } cmd_t;

  typedef struct packed {
    logic lt_ok;
    logic key_done;
    logic pend_valid;
    logic pend_match;
    logic walk_last;
    logic out_free;
  } sts_t;

  function automatic letter_t letter_of(logic [7:0] code);
    logic [7:0] c;
    letter_t    r;
    c = code;
    if (c >= 8'h61 && c <= 8'h7a) begin
      c = c - 8'd32;
    end
    r.ok  = (c >= 8'h41 && c <= 8'h5a);
    r.idx = 5'(c - 8'h41);
    if (r.idx == LetterJ) begin
      r.idx = LetterI;
    end
    return r;
  endfunction

  function automatic logic [RowW-1:0] pos_row(logic [LetterW-1:0] p);
    logic [RowW-1:0] r;
    r = '0;
    for (int k = 1; k < GridSide; k++) begin
      if (p >= LetterW'(k * GridSide)) begin
        r = RowW'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [RowW-1:0] pos_col(logic [LetterW-1:0] p);
    logic [LetterW-1:0] base;
    base = LetterW'(pos_row(p) * GridSide);
    return RowW'(p - base);
  endfunction

  function automatic logic [RowW-1:0] wrap_inc(logic [RowW-1:0] v);
    return (v == RowW'(GridSide - 1)) ? '0 : v + RowW'(1);
  endfunction

  function automatic logic [LetterW-1:0] cell_at(logic [RowW-1:0] row,
                                                 logic [RowW-1:0] col);
    return LetterW'(row * GridSide) + LetterW'(col);
  endfunction

endpackage

[sv/playfair_digraph_cipher.sv]
// top level of the playfair digraph cipher: sequencer plus datapath
// depends on pfc_pkg, pfc_ctrl, pfc_datapath and playfair_digraph_cipher_macros.svh
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid_i/in_ready_o   | kind_i, char_code_i
//   out     | output    | out_valid_o/out_ready_i | cipher_char_o, pair_last_o
//
// key char, lone text letter or ignored word: taken while the sequencer stays idle
// key end: one alphabet letter per cycle through the square fill
// pair word: two position lookups, then two key square reads
// into the output register
// reset clears the sequencer, letter-used flags, counters and output valid
// a stalled output holds its word and the sequencer waits in the emit states
`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cipher_char_o,
  output logic       pair_last_o
);

  cmd_t cmd;
  sts_t sts;
  logic emit_any;
  logic in_cmd;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  pfc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_code_i   (char_code_i),
    .cmd_i         (cmd),
    .out_ready_i   (out_ready_i),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .cipher_char_o (cipher_char_o),
    .pair_last_o   (pair_last_o)
  );

  assign emit_any = cmd.emit0 || cmd.emit1;
  assign in_cmd   = cmd.place || cmd.hold || cmd.pair_text || cmd.pair_pad ||
                    cmd.fill_start;

  `PFC_ASSERT(a_emit_slot_free, clk_i, rst_ni, !emit_any || !out_valid_o || out_ready_i)
  `PFC_ASSERT(a_start_on_accept, clk_i, rst_ni, !in_cmd || (in_valid_i && in_ready_o))
  `PFC_ASSERT_NEXT(a_fill_closes_key, clk_i, rst_ni, cmd.fill_done, sts.key_done)
  `PFC_ASSERT_NEXT(a_second_marked, clk_i, rst_ni, cmd.emit1, out_valid_o && pair_last_o)

endmodule

[sv/pfc_ctrl.sv]
// sequencer for the playfair digraph cipher: input decode, fill walk, pair steps
// depends on pfc_pkg
module pfc_ctrl import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  kind_e  kind;
  logic   accept;

  assign kind   = kind_e'(kind_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_KEY_END: begin
              if (!sts_i.key_done) state_d = ST_FILL;
            end
            KIND_TEXT: begin
              if (sts_i.key_done && sts_i.lt_ok && sts_i.pend_valid) state_d = ST_LOOK_A;
            end
            KIND_MSG_END: begin
              if (sts_i.key_done && sts_i.pend_valid) state_d = ST_LOOK_A;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (sts_i.walk_last) state_d = ST_IDLE;
      end
      ST_LOOK_A: state_d = ST_LOOK_B;
      ST_LOOK_B: state_d = ST_EMIT0;
      ST_EMIT0: begin
        if (sts_i.out_free) state_d = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (kind)
            KIND_KEY: begin
              cmd_o.place = !sts_i.key_done && sts_i.lt_ok;
            end
            KIND_KEY_END: begin
              cmd_o.fill_start = !sts_i.key_done;
            end
            KIND_TEXT: begin
              if (sts_i.key_done && sts_i.lt_ok) begin
                cmd_o.hold      = !sts_i.pend_valid;
                cmd_o.pair_text = sts_i.pend_valid;
              end
            end
            KIND_MSG_END: begin
              cmd_o.pair_pad = sts_i.key_done && sts_i.pend_valid;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.fill_done = sts_i.walk_last;
      end
      ST_LOOK_A: cmd_o.look_a = 1'b1;
      ST_LOOK_B: cmd_o.look_b = 1'b1;
      ST_EMIT0:  cmd_o.emit0  = sts_i.out_free;
      ST_EMIT1:  cmd_o.emit1  = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/pfc_datapath.sv]
// key square, letter positions, pending letter, pair rules and output register
// depends on pfc_pkg
module pfc_datapath import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_code_i,
  input  cmd_t       cmd_i,
  input  logic       out_ready_i,
  output sts_t       sts_o,
  output logic       out_valid_o,
  output logic [6:0] cipher_char_o,
  output logic       pair_last_o
);

  logic [LetterW-1:0] key_square_q   [Cells];
  logic [LetterW-1:0] letter_place_q [LetterCount];
  logic [LetterCount-1:0] used_q;

  logic [LetterW-1:0] fill_count_q, walk_q;
  logic               key_done_q, pend_valid_q;
  logic [LetterW-1:0] pend_letter_q, a_q, b_q, pa_q, pb_q;
  logic               out_valid_q, last_q;
  logic [6:0]         cipher_q;

  letter_t            lt;
  logic [LetterW-1:0] place_idx, lp_addr, lp_rd, ks_addr, ks_rd, ea, eb;
  logic               place_en, pend_match, out_free;
  logic [RowW-1:0]    ra, ca, rb, cb;

  assign lt         = letter_of(char_code_i);
  assign pend_match = (pend_letter_q == lt.idx);
  assign out_free   = !out_valid_q || out_ready_i;

  // letter to place: key letter from the input or the alphabet walk
  assign place_idx = cmd_i.fill_step ? walk_q : lt.idx;
  assign place_en  = (cmd_i.place || (cmd_i.fill_step && walk_q != LetterJ)) &&
                     !used_q[place_idx] && (fill_count_q < LetterW'(Cells));

  assign lp_addr = cmd_i.look_b ? b_q : a_q;
  assign lp_rd   = letter_place_q[lp_addr];

  // pair rules on registered positions
  assign ra = pos_row(pa_q);
  assign ca = pos_col(pa_q);
  assign rb = pos_row(pb_q);
  assign cb = pos_col(pb_q);

  always_comb begin
    if (ra == rb) begin
      ea = cell_at(ra, wrap_inc(ca));
      eb = cell_at(rb, wrap_inc(cb));
    end else if (ca == cb) begin
      ea = cell_at(wrap_inc(ra), ca);
      eb = cell_at(wrap_inc(rb), cb);
    end else begin
      ea = cell_at(ra, cb);
      eb = cell_at(rb, ca);
    end
  end

  assign ks_addr = cmd_i.emit1 ? eb : ea;
  assign ks_rd   = key_square_q[ks_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      fill_count_q <= '0;
      walk_q       <= '0;
      key_done_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (place_en) begin
        used_q[place_idx] <= 1'b1;
        fill_count_q      <= fill_count_q + LetterW'(1);
      end
      if (cmd_i.fill_start) begin
        walk_q <= '0;
      end else if (cmd_i.fill_step) begin
        walk_q <= walk_q + LetterW'(1);
      end
      if (cmd_i.fill_done) key_done_q <= 1'b1;
      if (cmd_i.hold) begin
        pend_valid_q <= 1'b1;
      end else if ((cmd_i.pair_text && !pend_match) || cmd_i.pair_pad) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.emit0 || cmd_i.emit1) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      key_square_q[fill_count_q]  <= place_idx;
      letter_place_q[place_idx]   <= fill_count_q;
    end
    if (cmd_i.hold) pend_letter_q <= lt.idx;
    if (cmd_i.pair_text) begin
      a_q <= pend_letter_q;
      b_q <= pend_match ? LetterX : lt.idx;
    end else if (cmd_i.pair_pad) begin
      a_q <= pend_letter_q;
      b_q <= LetterX;
    end
    if (cmd_i.look_a) pa_q <= lp_rd;
    if (cmd_i.look_b) pb_q <= lp_rd;
    if (cmd_i.emit0 || cmd_i.emit1) begin
      cipher_q <= AsciiA + 7'(ks_rd);
      last_q   <= cmd_i.emit1;
    end
  end

  assign sts_o.lt_ok      = lt.ok;
  assign sts_o.key_done   = key_done_q;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.pend_match = pend_match;
  assign sts_o.walk_last  = (walk_q == LetterLast);
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign cipher_char_o = cipher_q;
  assign pair_last_o   = last_q;

endmodule

[tb/sv/playfair_digraph_cipher_test.sv]
// self-checking testbench for playfair_digraph_cipher: a directed table, then random words,
// each checked against a behavioral Playfair key square and pair encryptor kept here
// depends on pfc_pkg and the playfair_digraph_cipher rtl
`timescale 1ns / 100ps

module playfair_digraph_cipher_test;
  import pfc_pkg::*;

  localparam int RandomWords = 540;
  localparam int HoldCycles  = 400;
  localparam int WatchLimit  = 3000;
  localparam int TailCycles  = 40;
  localparam int HoldAt      = 200;

  typedef struct {
    kind_e      k;
    logic [7:0] c;
    bit         typed;
  } stim_row_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } cipher_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  kind_e      kind = KIND_KEY;
  logic [7:0] code = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] cipher_char;
  logic       pair_last;
  bit         cur_typed = 1'b0;

  logic [4:0] square [Cells];
  logic [4:0] cell_of [LetterCount];
  bit         placed [LetterCount];
  int         filled;
  bit         key_closed;
  bit         held_valid;
  logic [4:0] held_letter;

  cipher_word_t cipher_q [$];
  stim_row_t    rows [$];

  int  errors;
  int  words_sent;
  int  letters_checked;
  int  stall_cycles;
  int  burst_left;
  bit  hold_request;
  bit  hold_fired;

  always #2 clk = ~clk;

  playfair_digraph_cipher u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .char_code_i   (code),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .cipher_char_o (cipher_char),
    .pair_last_o   (pair_last)
  );

  function automatic letter_t fold_letter(logic [7:0] c);
    logic [7:0] u;
    letter_t    r;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    r.ok  = (u >= "A" && u <= "Z");
    r.idx = r.ok ? 5'(u - "A") : '0;
    if (r.idx == LetterJ) begin
      r.idx = LetterI;
    end
    return r;
  endfunction

  task automatic place_key_letter(logic [4:0] li);
    if (!placed[li] && filled < Cells) begin
      square[filled] = li;
      cell_of[li]    = 5'(filled);
      placed[li]     = 1'b1;
      filled++;
    end
  endtask

  task automatic push_pair(logic [4:0] a, logic [4:0] b);
    int pa, pb, ra, ca, rb, cb, ea, eb;
    pa = cell_of[a];
    pb = cell_of[b];
    ra = pa / GridSide;
    ca = pa % GridSide;
    rb = pb / GridSide;
    cb = pb % GridSide;
    if (ra == rb) begin
      ea = ra * GridSide + (ca + 1) % GridSide;
      eb = rb * GridSide + (cb + 1) % GridSide;
    end else if (ca == cb) begin
      ea = ((ra + 1) % GridSide) * GridSide + ca;
      eb = ((rb + 1) % GridSide) * GridSide + cb;
    end else begin
      ea = ra * GridSide + cb;
      eb = rb * GridSide + ca;
    end
    cipher_q.push_back('{ch: AsciiA + 7'(square[ea]), last: 1'b0});
    cipher_q.push_back('{ch: AsciiA + 7'(square[eb]), last: 1'b1});
  endtask

  task automatic encipher_word(kind_e k, logic [7:0] c);
    letter_t lt;
    lt = fold_letter(c);
    case (k)
      KIND_KEY: begin
        if (!key_closed && lt.ok) begin
          place_key_letter(lt.idx);
        end
      end
      KIND_KEY_END: begin
        if (!key_closed) begin
          for (int i = 0; i < LetterCount; i++) begin
            if (5'(i) != LetterJ) begin
              place_key_letter(5'(i));
            end
          end
          key_closed = 1'b1;
        end
      end
      KIND_TEXT: begin
        if (key_closed && lt.ok) begin
          if (!held_valid) begin
            held_letter = lt.idx;
            held_valid  = 1'b1;
          end else if (held_letter == lt.idx) begin
            push_pair(held_letter, LetterX);
          end else begin
            push_pair(held_letter, lt.idx);
            held_valid = 1'b0;
          end
        end
      end
      default: begin
        if (key_closed && held_valid) begin
          push_pair(held_letter, LetterX);
          held_valid = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    cipher_word_t w;
    int           n0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n0 = cipher_q.size();
        encipher_word(kind, code);
        // typed rows expect no word at all
        if (cur_typed) begin
          while (cipher_q.size() > n0) begin
            void'(cipher_q.pop_back());
          end
        end
        words_sent++;
      end
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected word cipher_char %0d pair_last %0d", cipher_char, pair_last);
          errors++;
        end else begin
          w = cipher_q.pop_front();
          if (cipher_char !== w.ch) begin
            $error("cipher_char expected %0d actual %0d", w.ch, cipher_char);
            errors++;
          end
          if (pair_last !== w.last) begin
            $error("pair_last expected %0d actual %0d", w.last, pair_last);
            errors++;
          end
          letters_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchLimit) begin
      $display("no handshake for %0d cycles", stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 55) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else if (n < 90) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (n < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(15, 60)) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          repeat ($urandom_range(30, 80)) @(posedge clk);
        end
      end
    end
  end

  task automatic offer_word(kind_e k, logic [7:0] c, bit typed);
    in_valid  <= 1'b1;
    kind      <= k;
    code      <= c;
    cur_typed <= typed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap();
    int r;
    if (hold_request) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = 30;
    end else if (r >= 55) begin
      in_valid <= 1'b0;
      if (r < 92) begin
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        repeat ($urandom_range(8, 40)) @(posedge clk);
      end
    end
  endtask

  task automatic row(kind_e k, logic [7:0] c, bit typed);
    rows.push_back('{k: k, c: c, typed: typed});
  endtask

  initial begin : stimulus
    int         useful;
    int         pick;
    kind_e      k;
    logic [7:0] c;
    logic [7:0] prev_code;

    // text before the key closes, then key letters with case, J, repeats and junk bytes
    row(KIND_TEXT,    "A",   1'b1);
    row(KIND_MSG_END, "A",   1'b1);
    row(KIND_KEY,     "p",   1'b1);
    row(KIND_KEY,     "L",   1'b1);
    row(KIND_KEY,     "a",   1'b1);
    row(KIND_KEY,     "Y",   1'b1);
    row(KIND_KEY,     "j",   1'b1);
    row(KIND_KEY,     "I",   1'b1);
    row(KIND_KEY,     "5",   1'b1);
    row(KIND_KEY,     8'hC1, 1'b1);
    row(KIND_KEY,     8'hFF, 1'b1);
    row(KIND_KEY,     8'h00, 1'b1);
    row(KIND_KEY,     "z",   1'b1);
    row(KIND_KEY,     "X",   1'b1);
    row(KIND_KEY_END, 8'h00, 1'b1);
    // key words after the key end change nothing
    row(KIND_KEY,     "B",   1'b1);
    row(KIND_KEY_END, 8'hFF, 1'b1);
    row(KIND_MSG_END, 8'h00, 1'b1);
    // same row, same column with a junk byte between, doubled x, j in text, padding
    row(KIND_TEXT,    "P",   1'b0);
    row(KIND_TEXT,    "A",   1'b0);
    row(KIND_TEXT,    "p",   1'b0);
    row(KIND_TEXT,    8'hDA, 1'b0);
    row(KIND_TEXT,    "z",   1'b0);
    row(KIND_TEXT,    "x",   1'b0);
    row(KIND_TEXT,    "X",   1'b0);
    row(KIND_TEXT,    "J",   1'b0);
    row(KIND_TEXT,    "W",   1'b0);
    row(KIND_MSG_END, "W",   1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      offer_word(rows[i].k, rows[i].c, rows[i].typed);
      idle_gap();
    end

    useful    = 0;
    prev_code = "A";
    while (useful < RandomWords) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        k = KIND_TEXT;
        if ($urandom_range(0, 5) == 0) begin
          c = prev_code ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end else begin
          c = 8'(65 + $urandom_range(0, 25)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end
        prev_code = c;
        useful++;
      end else if (pick < 80) begin
        k = KIND_MSG_END;
        c = 8'($urandom_range(0, 255));
        useful++;
      end else if (pick < 90) begin
        k = KIND_TEXT;
        c = 8'($urandom_range(0, 255));
      end else if (pick < 95) begin
        k = KIND_KEY;
        c = 8'($urandom_range(0, 255));
      end else begin
        k = KIND_KEY_END;
        c = 8'($urandom_range(0, 255));
      end
      if (useful >= HoldAt && !hold_fired) begin
        hold_request = 1'b1;
        hold_fired   = 1'b1;
      end
      offer_word(k, c, 1'b0);
      idle_gap();
    end
    in_valid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d input words (%0d from the directed table), %0d cipher letters checked",
             words_sent, rows.size(), letters_checked);
    $display("including doubled letters, x padding, ignored bytes and a %0d-cycle output hold",
             HoldCycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_ctrl.sv
sv/pfc_datapath.sv
sv/playfair_digraph_cipher.sv
tb/sv/playfair_digraph_cipher_test.sv
